FILE: rtl/mrvl_pkg.sv
`timescale 1ns / 1ps

package mrvl_pkg;

   // field widths
   localparam int SAMPLE_W = 12;
   localparam int LEVEL_W  = 15;
   localparam int SQ_W     = 24;   // one squared sample
   localparam int SUM_W    = 30;   // running sum of squares, window up to 64
   localparam int NUM_W    = 55;   // scaled sum of squares
   localparam int DEN_W    = 25;   // window times denominator base, window up to 64
   localparam int PROD_W   = 40;   // partial root times denominator
   localparam int CAND_W   = 57;   // trial square times denominator
   localparam int BIT_W    = 4;    // index of the root bit under test

   // level = floor(sqrt(S * 4369^2 / (WINDOW * 546^2)))
   // (65535 / 8190 reduced by their common factor 15)
   localparam logic [DEN_W-1:0] ROOT_SCALE = 25'd19088161;
   localparam int DEN_BASE = 298116;

   localparam int QUEUE_DEPTH = 2;

   typedef enum logic [2:0] {
      FRONT_IDLE,
      FRONT_SQUARE,
      FRONT_SUM,
      FRONT_SCALE,
      FRONT_PUSH
   } front_state_type;

   typedef enum logic [1:0] {
      BACK_IDLE,
      BACK_ROOT,
      BACK_SEND
   } back_state_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

FILE: rtl/mrvl_front.sv
`timescale 1ns / 1ps

module mrvl_front #(
   parameter int WINDOW = 20
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [mrvl_pkg::SAMPLE_W-1:0]    req_sample,
   input  mrvl_pkg::queue_status_type       q_status,
   output logic                             push_valid,
   output logic [mrvl_pkg::NUM_W-1:0]       push_num
);

   localparam int PTR_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
   localparam int CNT_W = $clog2(WINDOW + 1);

   mrvl_pkg::front_state_type state_ff, state_in;

   logic [mrvl_pkg::SAMPLE_W-1:0] window_mem [WINDOW];
   logic [mrvl_pkg::SAMPLE_W-1:0] rd_ff;
   logic [mrvl_pkg::SAMPLE_W-1:0] sample_ff, sample_in;
   logic [mrvl_pkg::SQ_W-1:0]     sq_new_ff, sq_new_in;
   logic [mrvl_pkg::SQ_W-1:0]     sq_old_ff, sq_old_in;
   logic [mrvl_pkg::SUM_W-1:0]    sum_ff, sum_in;
   logic [mrvl_pkg::NUM_W-1:0]    num_ff, num_in;
   logic [PTR_W-1:0]              ptr_ff, ptr_in;
   logic [CNT_W-1:0]              cnt_ff, cnt_in;
   logic                          accept;
   logic                          window_full;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         mrvl_pkg::FRONT_IDLE: begin
            if (req_valid) state_in = mrvl_pkg::FRONT_SQUARE;
         end
         mrvl_pkg::FRONT_SQUARE: state_in = mrvl_pkg::FRONT_SUM;
         mrvl_pkg::FRONT_SUM:    state_in = mrvl_pkg::FRONT_SCALE;
         mrvl_pkg::FRONT_SCALE:  state_in = mrvl_pkg::FRONT_PUSH;
         mrvl_pkg::FRONT_PUSH: begin
            if (!q_status.full) state_in = mrvl_pkg::FRONT_IDLE;
         end
         default: state_in = mrvl_pkg::FRONT_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req_stall  = 1'b1;
      push_valid = 1'b0;
      case (state_ff)
         mrvl_pkg::FRONT_IDLE: req_stall  = 1'b0;
         mrvl_pkg::FRONT_PUSH: push_valid = 1'b1;
         default: begin
            req_stall  = 1'b1;
            push_valid = 1'b0;
         end
      endcase
   end

   assign accept      = req_valid && !req_stall;
   assign push_num    = num_ff;
   // entries past the fill count are treated as zero, not read from the window
   assign window_full = (cnt_ff == CNT_W'(WINDOW));

   // datapath next values
   always_comb begin
      sample_in = sample_ff;
      sq_new_in = sq_new_ff;
      sq_old_in = sq_old_ff;
      sum_in    = sum_ff;
      num_in    = num_ff;
      ptr_in    = ptr_ff;
      cnt_in    = cnt_ff;
      if (accept) sample_in = req_sample;
      case (state_ff)
         mrvl_pkg::FRONT_SQUARE: begin
            sq_new_in = mrvl_pkg::SQ_W'(sample_ff) * mrvl_pkg::SQ_W'(sample_ff);
            sq_old_in = window_full ?
                        mrvl_pkg::SQ_W'(rd_ff) * mrvl_pkg::SQ_W'(rd_ff) : '0;
            ptr_in    = (ptr_ff == PTR_W'(WINDOW - 1)) ? '0 : ptr_ff + PTR_W'(1);
            if (!window_full) cnt_in = cnt_ff + CNT_W'(1);
         end
         mrvl_pkg::FRONT_SUM: begin
            sum_in = sum_ff + mrvl_pkg::SUM_W'(sq_new_ff) - mrvl_pkg::SUM_W'(sq_old_ff);
         end
         mrvl_pkg::FRONT_SCALE: begin
            num_in = mrvl_pkg::NUM_W'(sum_ff) * mrvl_pkg::NUM_W'(mrvl_pkg::ROOT_SCALE);
         end
         default: begin
            num_in = num_ff;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mrvl_pkg::FRONT_IDLE;
         ptr_ff   <= '0;
         cnt_ff   <= '0;
         sum_ff   <= '0;
      end else begin
         state_ff <= state_in;
         ptr_ff   <= ptr_in;
         cnt_ff   <= cnt_in;
         sum_ff   <= sum_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      sample_ff <= sample_in;
      sq_new_ff <= sq_new_in;
      sq_old_ff <= sq_old_in;
      num_ff    <= num_in;
   end

   // sample window: oldest entry read at the pointer, then overwritten
   always_ff @(posedge clock) begin
      rd_ff <= window_mem[ptr_ff];
      if (state_ff == mrvl_pkg::FRONT_SQUARE) window_mem[ptr_ff] <= sample_ff;
   end

`ifndef SYNTHESIS
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(WINDOW))
      else $error("fill count past window");
`endif

endmodule

FILE: rtl/mrvl_queue.sv
`timescale 1ns / 1ps

module mrvl_queue (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          push_valid,
   input  logic [mrvl_pkg::NUM_W-1:0]    push_num,
   input  logic                          pop,
   output logic [mrvl_pkg::NUM_W-1:0]    pop_num,
   output mrvl_pkg::queue_status_type    q_status
);

   localparam int IDX_W = $clog2(mrvl_pkg::QUEUE_DEPTH);
   localparam int CNT_W = $clog2(mrvl_pkg::QUEUE_DEPTH + 1);

   logic [mrvl_pkg::NUM_W-1:0] entry_ff [mrvl_pkg::QUEUE_DEPTH];
   logic [IDX_W-1:0]           wr_ff, wr_in;
   logic [IDX_W-1:0]           rd_ff, rd_in;
   logic [CNT_W-1:0]           cnt_ff, cnt_in;
   logic                       do_push;
   logic                       do_pop;

   assign q_status.full  = (cnt_ff == CNT_W'(mrvl_pkg::QUEUE_DEPTH));
   assign q_status.empty = (cnt_ff == '0);
   assign do_push        = push_valid && !q_status.full;
   assign do_pop         = pop && !q_status.empty;
   assign pop_num        = entry_ff[rd_ff];

   // pointers and count
   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (do_push) wr_in = wr_ff + IDX_W'(1);
      if (do_pop)  rd_in = rd_ff + IDX_W'(1);
      if (do_push && !do_pop) cnt_in = cnt_ff + CNT_W'(1);
      if (!do_push && do_pop) cnt_in = cnt_ff - CNT_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) entry_ff[wr_ff] <= push_num;
   end

`ifndef SYNTHESIS
   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> !q_status.empty)
      else $error("back end popped an empty queue");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(mrvl_pkg::QUEUE_DEPTH))
      else $error("queue count overflow");
`endif

endmodule

FILE: rtl/mrvl_back.sv
`timescale 1ns / 1ps

module mrvl_back #(
   parameter int WINDOW = 20
) (
   input  logic                          clock,
   input  logic                          reset,
   input  mrvl_pkg::queue_status_type    q_status,
   input  logic [mrvl_pkg::NUM_W-1:0]    q_num,
   output logic                          pop,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [mrvl_pkg::LEVEL_W-1:0]  rsp_level
);

   localparam logic [mrvl_pkg::DEN_W-1:0] DEN =
      mrvl_pkg::DEN_W'(WINDOW * mrvl_pkg::DEN_BASE);

   mrvl_pkg::back_state_type state_ff, state_in;

   logic [mrvl_pkg::NUM_W-1:0]   num_ff, num_in;
   logic [mrvl_pkg::NUM_W-1:0]   acc_ff, acc_in;    // root^2 * DEN
   logic [mrvl_pkg::PROD_W-1:0]  lin_ff, lin_in;    // root * DEN
   logic [mrvl_pkg::LEVEL_W-1:0] root_ff, root_in;
   logic [mrvl_pkg::BIT_W-1:0]   bit_ff, bit_in;
   logic [mrvl_pkg::CAND_W-1:0]  cand;
   logic                         take;
   logic                         load;

   // a new beat is loaded when idle or as the held result leaves
   assign load = !q_status.empty &&
                 ((state_ff == mrvl_pkg::BACK_IDLE) ||
                  ((state_ff == mrvl_pkg::BACK_SEND) && !rsp_stall));

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         mrvl_pkg::BACK_IDLE: begin
            if (load) state_in = mrvl_pkg::BACK_ROOT;
         end
         mrvl_pkg::BACK_ROOT: begin
            if (bit_ff == '0) state_in = mrvl_pkg::BACK_SEND;
         end
         mrvl_pkg::BACK_SEND: begin
            if (!rsp_stall) state_in = load ? mrvl_pkg::BACK_ROOT : mrvl_pkg::BACK_IDLE;
         end
         default: state_in = mrvl_pkg::BACK_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      rsp_valid = 1'b0;
      case (state_ff)
         mrvl_pkg::BACK_SEND: rsp_valid = 1'b1;
         default:             rsp_valid = 1'b0;
      endcase
   end

   assign pop       = load;
   assign rsp_level = root_ff;

   // trial: (root | 2^k)^2 * DEN = acc + lin * 2^(k+1) + DEN * 4^k
   assign cand = mrvl_pkg::CAND_W'(acc_ff)
               + (mrvl_pkg::CAND_W'(lin_ff) << ({1'b0, bit_ff} + 5'd1))
               + (mrvl_pkg::CAND_W'(DEN) << {bit_ff, 1'b0});
   assign take = (cand <= mrvl_pkg::CAND_W'(num_ff));

   // one root bit per cycle, most significant first
   always_comb begin
      num_in  = num_ff;
      acc_in  = acc_ff;
      lin_in  = lin_ff;
      root_in = root_ff;
      bit_in  = bit_ff;
      if (load) begin
         num_in  = q_num;
         acc_in  = '0;
         lin_in  = '0;
         root_in = '0;
         bit_in  = mrvl_pkg::BIT_W'(mrvl_pkg::LEVEL_W - 1);
      end else if (state_ff == mrvl_pkg::BACK_ROOT) begin
         if (take) begin
            acc_in  = cand[mrvl_pkg::NUM_W-1:0];
            lin_in  = lin_ff + (mrvl_pkg::PROD_W'(DEN) << bit_ff);
            root_in = root_ff | (mrvl_pkg::LEVEL_W'(1) << bit_ff);
         end
         if (bit_ff != '0) bit_in = bit_ff - mrvl_pkg::BIT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= mrvl_pkg::BACK_IDLE;
      else       state_ff <= state_in;
   end

   always_ff @(posedge clock) begin
      num_ff  <= num_in;
      acc_ff  <= acc_in;
      lin_ff  <= lin_in;
      root_ff <= root_in;
      bit_ff  <= bit_in;
   end

`ifndef SYNTHESIS
   a_acc_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == mrvl_pkg::BACK_ROOT) |-> (acc_ff <= num_ff))
      else $error("accepted square exceeds scaled sum");

   a_root_done: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == mrvl_pkg::BACK_ROOT) && (bit_ff == '0)) |=>
      (state_ff == mrvl_pkg::BACK_SEND))
      else $error("root search did not finish on last bit");
`endif

endmodule

FILE: rtl/moving_rms_volume_level.sv
// Moving-window RMS volume level.
// req_ channel: one 12-bit converter sample per beat (req_valid / req_stall).
// rsp_ channel: one 15-bit PWM compare level per sample (rsp_valid / rsp_stall),
//   floor(sqrt(sum of squares * 4369^2 / (WINDOW * 546^2))), 32767 at full scale.
// Front end: takes a sample, swaps it into the window memory, updates the
//   running sum of squares and scales it.
// A two-beat queue sits between front and back, so each side stalls on its own.
// Back end: bit-serial square root, one result bit per cycle, then the result
//   is held in its register until taken. The next sample is loaded as the held
//   result leaves, so the sustained rate is set by the root search.
// Reset (synchronous): clears the fill count, pointer, running sum and all
//   handshake state. Window entries not yet written count as zero through the
//   fill count, so there is no clearing pass.
// A stalled result holds rsp_level steady; the back end waits, the queue fills,
//   and then req_stall stays high.
`timescale 1ns / 1ps

module moving_rms_volume_level #(
   parameter int WINDOW = 20
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [mrvl_pkg::SAMPLE_W-1:0] req_sample,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [mrvl_pkg::LEVEL_W-1:0]  rsp_level
);

   mrvl_pkg::queue_status_type   q_status;
   logic                         push_valid;
   logic [mrvl_pkg::NUM_W-1:0]   push_num;
   logic [mrvl_pkg::NUM_W-1:0]   pop_num;
   logic                         pop;

   mrvl_front #(
      .WINDOW (WINDOW)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_sample (req_sample),
      .q_status   (q_status),
      .push_valid (push_valid),
      .push_num   (push_num)
   );

   mrvl_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_num   (push_num),
      .pop        (pop),
      .pop_num    (pop_num),
      .q_status   (q_status)
   );

   mrvl_back #(
      .WINDOW (WINDOW)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_status  (q_status),
      .q_num     (pop_num),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_level (rsp_level)
   );

endmodule

FILE: sim/moving_rms_volume_level_test.sv
`timescale 1ns / 1ps

module moving_rms_volume_level_test;

   localparam int WINDOW      = 20;
   localparam int LONG_HOLD   = 400;    // receiver hold-off, cycles
   localparam int IDLE_LIMIT  = 3000;   // cycles without any beat before giving up
   localparam int DRAIN_WAIT  = 40;     // extra wait after the last expected level
   localparam int RANDOM_ITEMS = 600;

   localparam logic [63:0] FULL_DUTY_SQ = 64'd65535 * 64'd65535;
   localparam logic [63:0] LEVEL_DEN    = 64'(WINDOW) * 64'd8190 * 64'd8190;

   typedef enum int {
      SHAPE_ANY,
      SHAPE_FULL,
      SHAPE_ZERO,
      SHAPE_QUIET,
      SHAPE_ONE_BIT
   } sample_shape_type;

   typedef struct {
      logic [mrvl_pkg::SAMPLE_W-1:0] sample;
      bit                            typed;
      logic [mrvl_pkg::LEVEL_W-1:0]  level;
   } dir_row_type;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          req_valid = 1'b0;
   logic                          req_stall;
   logic [mrvl_pkg::SAMPLE_W-1:0] req_sample = '0;
   logic                          rsp_valid;
   logic                          rsp_stall = 1'b0;
   logic [mrvl_pkg::LEVEL_W-1:0]  rsp_level;

   // predictor state: sample history (entry 0 newest) and running sum of squares
   logic [mrvl_pkg::SAMPLE_W-1:0] sample_hist [WINDOW];
   logic [mrvl_pkg::SUM_W-1:0]    sq_total;

   logic [mrvl_pkg::LEVEL_W-1:0]  level_queue [$];
   dir_row_type                   dir_rows [$];

   int  error_count    = 0;
   int  samples_sent   = 0;
   int  levels_checked = 0;
   int  idle_cycles    = 0;
   bit  calm           = 1'b0;   // no gaps on either side while set
   bit  long_hold_done = 1'b0;

   moving_rms_volume_level #(
      .WINDOW(WINDOW)
   ) u_top (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_sample (req_sample),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_level  (rsp_level)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // shift one sample into the history and return the level it produces
   function automatic logic [mrvl_pkg::LEVEL_W-1:0] push_sample_level(
      input logic [mrvl_pkg::SAMPLE_W-1:0] s);
      logic [63:0]                   wide_sum;
      logic [63:0]                   scaled;
      logic [63:0]                   trial;
      logic [15:0]                   root;
      logic [mrvl_pkg::SAMPLE_W-1:0] oldest;
      oldest = sample_hist[WINDOW-1];
      for (int i = WINDOW - 1; i > 0; i--)
         sample_hist[i] = sample_hist[i-1];
      sample_hist[0] = s;
      wide_sum = 64'(sq_total) + 64'(s) * 64'(s) - 64'(oldest) * 64'(oldest);
      sq_total = wide_sum[mrvl_pkg::SUM_W-1:0];
      scaled   = (64'(sq_total) * FULL_DUTY_SQ) / LEVEL_DEN;
      // root found one bit at a time from the top
      root = '0;
      for (int b = 15; b >= 0; b--) begin
         trial = 64'(root | (16'd1 << b));
         if (trial * trial <= scaled)
            root = root | (16'd1 << b);
      end
      return root[mrvl_pkg::LEVEL_W-1:0];
   endfunction

   // mostly back to back, some short gaps, a few long ones
   function automatic int pick_gap();
      int r;
      r = int'($urandom_range(0, 99));
      if (calm || r < 65)
         return 0;
      else if (r < 93)
         return int'($urandom_range(1, 3));
      else
         return int'($urandom_range(10, 50));
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("MISMATCH %s: got %0d, expected %0d (level beat %0d)",
               what, got, want, levels_checked);
      error_count++;
   endtask

   // offer one sample beat, hold it until accepted, then log the expected level
   task automatic send_sample(input logic [mrvl_pkg::SAMPLE_W-1:0] s, input bit typed,
                              input logic [mrvl_pkg::LEVEL_W-1:0] typed_level);
      logic [mrvl_pkg::LEVEL_W-1:0] predicted;
      int                           gap;
      gap = pick_gap();
      if (gap != 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid  = 1'b1;
      req_sample = s;
      do @(posedge clock); while (req_stall);
      predicted = push_sample_level(s);
      level_queue.push_back(typed ? typed_level : predicted);
      samples_sent++;
      @(negedge clock);
   endtask

   // result checker and beat activity counter
   always @(posedge clock) begin
      if (reset) begin
         idle_cycles <= 0;
      end else begin
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            idle_cycles <= 0;
         else
            idle_cycles <= idle_cycles + 1;
         if (rsp_valid && !rsp_stall) begin
            if (level_queue.size() == 0) begin
               report_mismatch("unexpected level beat", int'(rsp_level), -1);
            end else begin
               if (rsp_level !== level_queue[0])
                  report_mismatch("level", int'(rsp_level), int'(level_queue[0]));
               void'(level_queue.pop_front());
            end
            levels_checked++;
         end
      end
   end

   // watchdog
   initial begin
      while (idle_cycles < IDLE_LIMIT) @(posedge clock);
      $display("Timeout: no beat for %0d cycles, %0d levels outstanding",
               IDLE_LIMIT, level_queue.size());
      $display("Some tests failed");
      $finish;
   end

   // result side: random stalls, plus one long hold-off to back up the block
   initial begin
      int hold;
      hold = 0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (!long_hold_done && levels_checked >= 150) begin
            long_hold_done = 1'b1;
            hold = LONG_HOLD;
         end
         if (hold > 0) begin
            rsp_stall = 1'b1;
            hold--;
         end else begin
            rsp_stall = 1'b0;
            hold = pick_gap();
         end
         @(negedge clock);
      end
   end

   // reset, directed rows, random samples, drain and verdict
   initial begin
      dir_row_type                   row;
      sample_shape_type              shape;
      logic [mrvl_pkg::SAMPLE_W-1:0] s;
      int                            run_len;
      int                            r;
      int                            dir_count;

      for (int i = 0; i < WINDOW; i++)
         sample_hist[i] = '0;
      sq_total = '0;

      // zero after reset gives zero
      dir_rows.push_back('{sample: '0, typed: 1'b1, level: '0});
      // fill the window with full scale; the last one reaches the top level
      for (int i = 1; i < WINDOW; i++)
         dir_rows.push_back('{sample: '1, typed: 1'b0, level: '0});
      dir_rows.push_back('{sample: '1, typed: 1'b1, level: 15'd32767});
      // full window slides a full-scale sample out and in again
      dir_rows.push_back('{sample: '1, typed: 1'b1, level: 15'd32767});
      dir_rows.push_back('{sample: 12'hAAA, typed: 1'b0, level: '0});
      dir_rows.push_back('{sample: 12'h555, typed: 1'b0, level: '0});
      dir_rows.push_back('{sample: 12'h001, typed: 1'b0, level: '0});
      dir_rows.push_back('{sample: 12'h800, typed: 1'b0, level: '0});
      dir_count = dir_rows.size();

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (dir_rows[i]) begin
         row = dir_rows[i];
         send_sample(row.sample, row.typed, row.level);
      end

      // random runs of one sample shape; zero and full-scale runs can reach the extremes
      while (samples_sent < dir_count + RANDOM_ITEMS) begin
         r = int'($urandom_range(0, 99));
         if (r < 50)      shape = SHAPE_ANY;
         else if (r < 62) shape = SHAPE_FULL;
         else if (r < 74) shape = SHAPE_ZERO;
         else if (r < 87) shape = SHAPE_QUIET;
         else             shape = SHAPE_ONE_BIT;
         run_len = (shape == SHAPE_FULL || shape == SHAPE_ZERO) ?
                   int'($urandom_range(5, WINDOW + 5)) : int'($urandom_range(1, 30));
         calm = ($urandom_range(0, 4) == 0);
         for (int k = 0; k < run_len; k++) begin
            case (shape)
               SHAPE_ANY:     s = mrvl_pkg::SAMPLE_W'($urandom_range(0, 4095));
               SHAPE_FULL:    s = '1;
               SHAPE_ZERO:    s = '0;
               SHAPE_QUIET:   s = mrvl_pkg::SAMPLE_W'($urandom_range(0, 15));
               SHAPE_ONE_BIT: s = 12'd1 << $urandom_range(0, mrvl_pkg::SAMPLE_W - 1);
               default:       s = '0;
            endcase
            send_sample(s, 1'b0, '0);
         end
      end
      calm = 1'b0;
      req_valid = 1'b0;

      while (level_queue.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);

      $display("Sent %0d samples (%0d directed), checked %0d levels, %0d mismatches.",
               samples_sent, dir_count, levels_checked, error_count);
      $display("Covered warm-up, full-scale and zero windows, random stalls");
      $display("and a %0d-cycle receiver hold.", LONG_HOLD);
      if (error_count == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule
